// File: design/slr_pkg.sv
// Shared types, constants and the control store for the shuffled Lehmer generator.
package slr_pkg;

    localparam int unsigned GEN_W        = 31;
    localparam int unsigned MULT_W       = 15;
    localparam int unsigned PROD_W       = GEN_W + MULT_W;
    localparam int unsigned WARMUP_EXTRA = 8;

    localparam logic [GEN_W-1:0]  LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW1,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_DRAW0
    } t_step;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_GOTO,
        BR_DISPATCH,
        BR_LOOP
    } t_branch;

    typedef struct packed {
        logic ready;
        logic load;
        logic mul;
        logic div;
        logic div_gen;
        logic warm;
        logic draw;
    } t_ctrl;

    typedef struct packed {
        t_ctrl   ctl;
        t_branch br;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic xfer;
        logic need_init;
        logic cnt_last;
        logic out_busy;
    } t_seq_stat;

    function automatic t_uword urom(input t_step step);
        t_uword w;
        w = '{ctl: '0, br: BR_GOTO, target: ST_IDLE};
        unique case (step)
            ST_IDLE: begin
                w.ctl.ready = 1'b1;
                w.ctl.load  = 1'b1;
                w.ctl.mul   = 1'b1;
                w.ctl.div   = 1'b1;
                w.br        = BR_DISPATCH;
                w.target    = ST_WARM_MUL;
            end
            ST_DRAW1: begin
                w.ctl.draw = 1'b1;
                w.br       = BR_GOTO;
                w.target   = ST_IDLE;
            end
            ST_WARM_MUL: begin
                w.ctl.mul = 1'b1;
                w.br      = BR_NEXT;
            end
            ST_WARM_RED: begin
                w.ctl.warm = 1'b1;
                w.br       = BR_LOOP;
                w.target   = ST_WARM_MUL;
            end
            ST_DRAW0: begin
                w.ctl.mul     = 1'b1;
                w.ctl.div     = 1'b1;
                w.ctl.div_gen = 1'b1;
                w.br          = BR_GOTO;
                w.target      = ST_DRAW1;
            end
            default: begin
                w.br     = BR_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/slr_in_if.sv
// Input channel: command and seed with valid/ready handshake.
interface slr_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] seed;

    modport source (output valid, output command, output seed, input ready);
    modport sink   (input valid, input command, input seed, output ready);
endinterface

// File: design/slr_out_if.sv
// Output channel: random word with valid/ready handshake.
interface slr_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// File: design/shuffled_lehmer_rng.sv
// Shuffled Lehmer generator top level: datapath, shuffle table and sequencer.
// Draw: the transfer registers the product and bin index, then the swap step registers the result (multiply, swap);
//   the swap step is held while the output is stalled. Initialisation (reseed, or zero generator/held word):
//   the transfer loads the start value, the warm-up loop (multiply, reduce) fills the table, then multiply and swap.
// A new transfer is taken only back in idle. Reset: synchronous, active low; clears sequencer, generator word and
//   output valid; the shuffle table is not cleared, the first draw after reset initialises it.
module shuffled_lehmer_rng #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slr_in_if.sink     i_in,
    slr_out_if.source  o_out
);

    localparam int unsigned GW        = slr_pkg::GEN_W;
    localparam int unsigned PW        = slr_pkg::PROD_W;
    localparam int unsigned IDX_W     = $clog2(TABLE_SIZE);
    localparam int unsigned QW        = IDX_W + 1;
    localparam int unsigned CNT_W     = $clog2(TABLE_SIZE + slr_pkg::WARMUP_EXTRA);
    localparam logic [63:0] MOD64     = 64'(slr_pkg::LCG_MOD);
    localparam logic [63:0] BIN_WIDTH = 64'd1 + (MOD64 - 64'd1) / 64'(TABLE_SIZE);
    localparam int unsigned BIN_L     = $clog2(BIN_WIDTH);
    localparam int unsigned SH        = GW + BIN_L;
    localparam logic [63:0] MAGIC64   = ((64'd1 << SH) + BIN_WIDTH - 64'd1) / BIN_WIDTH;
    localparam logic [31:0] MAGIC     = MAGIC64[31:0];
    localparam logic [CNT_W-1:0] WARM_LAST =
        CNT_W'(TABLE_SIZE + slr_pkg::WARMUP_EXTRA - 1);
    localparam logic [CNT_W-1:0] TS_CNT = CNT_W'(TABLE_SIZE);
    localparam logic [QW-1:0]    TS_Q   = QW'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_SIZE - 1);

    slr_pkg::t_ctrl     ctl;
    slr_pkg::t_seq_stat stat;

    logic [GW-1:0]    r_gen;
    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    r_prod;
    logic [62:0]      r_qprod;
    logic [GW-1:0]    r_held;
    logic [GW-1:0]    r_out;
    logic             r_out_valid;
    logic [GW-1:0]    r_table [TABLE_SIZE];

    logic             xfer;
    logic             need_init;
    logic [31:0]      seed_mag;
    logic [GW-1:0]    start;
    logic [31:0]      red_sum;
    logic [GW-1:0]    red;
    logic [GW-1:0]    div_op;
    logic [QW-1:0]    q_idx;
    logic [IDX_W-1:0] idx_c;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_addr;

    slr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    assign i_in.ready = ctl.ready;
    assign xfer       = i_in.valid & ctl.ready;
    assign need_init  = (i_in.command == slr_pkg::CMD_RESEED) || (r_gen == '0)
                        || (r_held == '0);

    assign stat.xfer      = xfer;
    assign stat.need_init = need_init;
    assign stat.cnt_last  = (r_cnt == '0);
    assign stat.out_busy  = r_out_valid & ~o_out.ready;

    // start value: magnitude of a negative seed reduced mod 2^31-1, else 1
    always_comb begin
        seed_mag = ~$unsigned(i_in.seed) + 32'd1;
        start    = GW'(1);
        if (i_in.command == slr_pkg::CMD_RESEED && i_in.seed[31]) begin
            if (seed_mag[31]) begin
                start = GW'(1);
            end else if (seed_mag[30:0] == slr_pkg::LCG_MOD) begin
                start = '0;
            end else begin
                start = seed_mag[30:0];
            end
        end
    end

    // Mersenne reduction of the registered product
    always_comb begin
        red_sum = {1'b0, r_prod[GW-1:0]} + 32'(r_prod[PW-1:GW]);
        if (red_sum >= {1'b0, slr_pkg::LCG_MOD}) begin
            red = GW'(red_sum - {1'b0, slr_pkg::LCG_MOD});
        end else begin
            red = red_sum[GW-1:0];
        end
    end

    // bin index by reciprocal multiply, saturated
    assign div_op = ctl.div_gen ? r_gen : r_held;
    assign q_idx  = QW'(r_qprod >> SH);
    assign idx_c  = (q_idx >= TS_Q) ? IDX_MAX : q_idx[IDX_W-1:0];

    assign tbl_we   = ctl.warm ? (r_cnt < TS_CNT) : ctl.draw;
    assign tbl_addr = ctl.warm ? r_cnt[IDX_W-1:0] : idx_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.load) begin
                r_gen <= start;
                r_cnt <= WARM_LAST;
            end else if (ctl.warm) begin
                r_gen <= red;
                r_cnt <= r_cnt - CNT_W'(1);
            end else if (ctl.draw) begin
                r_gen <= red;
            end
            if (ctl.draw) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.mul) begin
            r_prod <= {{(PW-GW){1'b0}}, r_gen} * {{(PW-slr_pkg::MULT_W){1'b0}}, slr_pkg::LCG_MULT};
        end
        if (ctl.div) begin
            r_qprod <= {32'd0, div_op} * {31'd0, MAGIC};
        end
    end

    // shuffle table: a draw reads the old entry and writes the new generator word in one step; warm-up writes entries
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_addr] <= red;
        end
        if (ctl.draw) begin
            r_held <= r_table[idx_c];
            r_out  <= r_table[idx_c];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.random_word = r_out;

`ifndef NO_ASSERTIONS
    a_spaced_transfers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |=> !xfer)
        else $error("input transfers in consecutive cycles");

    a_init_loads_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && need_init) |=> (r_cnt == WARM_LAST))
        else $error("initialisation did not load warm-up count");

    a_gen_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != slr_pkg::LCG_MOD)
        else $error("generator word not reduced");

    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.random_word != slr_pkg::LCG_MOD))
        else $error("output word equals modulus");
`endif

endmodule

// File: design/slr_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
module slr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slr_pkg::t_seq_stat i_stat,
    output slr_pkg::t_ctrl    o_ctl
);

    slr_pkg::t_step  r_pc;
    slr_pkg::t_step  n_pc;
    slr_pkg::t_uword w;
    logic            go_draw;
    logic            go_init;
    logic            hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= slr_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w       = slr_pkg::urom(r_pc);
        go_draw = i_stat.xfer & ~i_stat.need_init;
        go_init = i_stat.xfer & i_stat.need_init;
        hold    = w.ctl.draw & i_stat.out_busy;
        o_ctl   = w.ctl;
        if (w.br == slr_pkg::BR_DISPATCH) begin
            o_ctl.mul  = w.ctl.mul & go_draw;
            o_ctl.div  = w.ctl.div & go_draw;
            o_ctl.load = w.ctl.load & go_init;
        end
        if (hold) begin
            o_ctl.draw = 1'b0;
        end
        unique case (w.br)
            slr_pkg::BR_NEXT:     n_pc = slr_pkg::t_step'(r_pc + 3'd1);
            slr_pkg::BR_GOTO:     n_pc = w.target;
            slr_pkg::BR_DISPATCH: n_pc = go_init ? w.target :
                                         (go_draw ? slr_pkg::t_step'(r_pc + 3'd1) : r_pc);
            slr_pkg::BR_LOOP:     n_pc = i_stat.cnt_last ? slr_pkg::t_step'(r_pc + 3'd1)
                                                         : w.target;
            default:              n_pc = slr_pkg::ST_IDLE;
        endcase
        if (hold) begin
            n_pc = r_pc;
        end
    end

endmodule

// File: tb/slr_checker.sv
`timescale 1ns / 1ps
// Checker for the shuffled Lehmer generator: predicts each word and compares it with the output.
module slr_checker #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    slr_in_if    i_req,
    slr_out_if   i_rsp,
    output int   o_err_count,
    output int   o_pending
);

    localparam int unsigned BIN_SPAN = 1 + (32'h7FFF_FFFE / TABLE_SIZE);

    typedef logic [slr_pkg::GEN_W-1:0] t_word;

    t_word gen_word;
    t_word held_word;
    t_word shuffle_mem [TABLE_SIZE];
    t_word expected_words [$];
    t_word want;
    int    err_tally   = 0;
    int    pending_cnt = 0;

    assign o_err_count = err_tally;
    assign o_pending   = pending_cnt;

    function automatic t_word lehmer_step(input t_word x);
        logic [63:0] prod;
        prod = 64'(slr_pkg::LCG_MULT) * 64'(x);
        return t_word'(prod % 64'(slr_pkg::LCG_MOD));
    endfunction

    // warm-up steps, table filled from the top entry down on the last TABLE_SIZE of them
    function automatic void warm_start(input t_word start);
        t_word w;
        w = start;
        for (int k = int'(TABLE_SIZE + slr_pkg::WARMUP_EXTRA) - 1; k >= 0; k--) begin
            w = lehmer_step(w);
            if (k < int'(TABLE_SIZE)) shuffle_mem[k] = w;
        end
        gen_word  = w;
        held_word = shuffle_mem[0];
    endfunction

    function automatic t_word predict_word(input logic cmd, input logic [31:0] seed_bits);
        logic [31:0] mag;
        int unsigned slot;
        if (cmd == slr_pkg::CMD_RESEED) begin
            mag = 32'd1;
            if (seed_bits[31]) mag = (32'd0 - seed_bits) % 32'h7FFF_FFFF;
            warm_start(t_word'(mag));
        end else if (held_word == '0 || gen_word == '0) begin
            warm_start(t_word'(1));
        end
        gen_word = lehmer_step(gen_word);
        slot = 32'(held_word) / BIN_SPAN;
        if (slot >= TABLE_SIZE) slot = TABLE_SIZE - 1;
        held_word = shuffle_mem[slot];
        shuffle_mem[slot] = gen_word;
        return held_word;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_word  = '0;
            held_word = '0;
            expected_words.delete();
            pending_cnt <= 0;
        end else begin
            // pop before push: a result never belongs to a command taken on the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_words.size() == 0) begin
                    err_tally <= err_tally + 1;
                    $display("%0t: random_word expected none actual %0d", $time,
                             i_rsp.random_word);
                end else begin
                    want = expected_words.pop_front();
                    if (i_rsp.random_word !== want) begin
                        err_tally <= err_tally + 1;
                        $display("%0t: random_word expected %0d actual %0d", $time,
                                 want, i_rsp.random_word);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                expected_words.push_back(predict_word(i_req.command, i_req.seed));
            pending_cnt <= expected_words.size();
        end
    end

endmodule

// File: tb/tb_shuffled_lehmer_rng.sv
`timescale 1ns / 1ps
// Testbench top for the shuffled Lehmer generator: clock, reset, stimulus and verdict.
module tb_shuffled_lehmer_rng;

    localparam int unsigned TABLE_SIZE = 32;
    localparam int          RANDOM_ITEMS = 1330;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int err_count;
    int pending;

    int unsigned burst_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_stall_left = 0;

    slr_in_if  req_ch ();
    slr_out_if rsp_ch ();

    shuffled_lehmer_rng #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    slr_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.command = slr_pkg::CMD_DRAW;
        req_ch.seed    = '0;
        rsp_ch.ready   = 1'b0;
    end

    // receiver: modes of no stalls, sparse short stalls and heavy long stalls
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(64, 256);
        end else begin
            rx_mode_left--;
        end
        if (rx_stall_left != 0) begin
            rsp_ch.ready = 1'b0;
            rx_stall_left--;
        end else begin
            rsp_ch.ready = 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 2) == 0) rx_stall_left = $urandom_range(1, 12);
                default: ;
            endcase
        end
    end

    task automatic send_cmd(input logic cmd, input logic [31:0] seed_val);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid   = 1'b0;
                req_ch.command = 1'($urandom);
                req_ch.seed    = $urandom;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        req_ch.valid   = 1'b1;
        req_ch.command = cmd;
        req_ch.seed    = seed_val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [31:0] s;
        s = $urandom;
        if ($urandom_range(0, 19) != 0) begin
            send_cmd(slr_pkg::CMD_DRAW, s);
        end else begin
            case ($urandom_range(0, 15))
                0: s = 32'h8000_0001;   // magnitude equals the modulus
                1: s = 32'h8000_0000;
                2: s = 32'h8000_0002;
                3: s = 32'h0000_0000;
                4: s = 32'h7FFF_FFFF;
                default: ;
            endcase
            send_cmd(slr_pkg::CMD_RESEED, s);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // first draw after reset initialises from 1
        send_cmd(slr_pkg::CMD_DRAW, 32'hFFFF_FFFF);
        send_cmd(slr_pkg::CMD_DRAW, 32'h0000_0000);
        send_cmd(slr_pkg::CMD_DRAW, 32'h1234_5678);
        send_cmd(slr_pkg::CMD_RESEED, 32'h0000_0000);
        send_cmd(slr_pkg::CMD_RESEED, 32'h7FFF_FFFF);
        send_cmd(slr_pkg::CMD_DRAW, 32'h0);
        send_cmd(slr_pkg::CMD_RESEED, 32'hFFFF_FFFF);
        send_cmd(slr_pkg::CMD_RESEED, 32'hFFFF_FFFE);
        send_cmd(slr_pkg::CMD_DRAW, 32'h0);
        // zero start value, then a draw that reinitialises
        send_cmd(slr_pkg::CMD_RESEED, 32'h8000_0001);
        send_cmd(slr_pkg::CMD_DRAW, 32'h0);
        send_cmd(slr_pkg::CMD_DRAW, 32'h0);
        send_cmd(slr_pkg::CMD_RESEED, 32'h8000_0001);
        send_cmd(slr_pkg::CMD_RESEED, 32'h8000_0001);
        send_cmd(slr_pkg::CMD_RESEED, 32'h8000_0000);
        send_cmd(slr_pkg::CMD_DRAW, 32'h0);
        send_cmd(slr_pkg::CMD_RESEED, 32'h8000_0002);
        send_cmd(slr_pkg::CMD_DRAW, 32'hAAAA_AAAA);
        send_cmd(slr_pkg::CMD_DRAW, 32'h5555_5555);
        send_cmd(slr_pkg::CMD_RESEED, -32'sd12345);
        for (int k = 0; k < 4; k++) send_cmd(slr_pkg::CMD_DRAW, $urandom);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 600) burst_left = 200;     // long stretch with no sender gaps
            send_random();
        end

        @(negedge i_clk);
        req_ch.valid = 1'b0;

        @(posedge i_clk);
        for (int w = 0; w < 5000 && pending != 0; w++) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (pending != 0)
            $display("%0t: expected %0d more transfers, actual 0", $time, pending);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
design/slr_pkg.sv
design/slr_in_if.sv
design/slr_out_if.sv
design/slr_seq.sv
design/shuffled_lehmer_rng.sv
tb/slr_checker.sv
tb/tb_shuffled_lehmer_rng.sv
